@@ hdl/aclp_pkg.sv @@
// ----------------------------------------------------------------------------
// ASCII control line parser package
// Character codes, limits, group bases, result codes, the parse phase type and character tests.
// ----------------------------------------------------------------------------
package aclp_pkg;

  // Characters that steer the parser.
  localparam logic [7:0] CHR_NL    = 8'h0A;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_VT    = 8'h0B;
  localparam logic [7:0] CHR_FF    = 8'h0C;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  // Accumulator limits.
  localparam logic [7:0]  INDEX_SAT = 8'd255;
  localparam logic [10:0] VALUE_SAT = 11'd1025;
  localparam logic [10:0] LEVEL_MAX = 11'd1024;

  // Group bases of the index.
  localparam logic [7:0] CV_BASE     = 8'd0;
  localparam logic [7:0] KNOB_BASE   = 8'd10;
  localparam logic [7:0] KNOB_END    = 8'd20;
  localparam logic [7:0] BUTTON_BASE = 8'd30;
  localparam logic [7:0] BUTTON_END  = 8'd40;

  // Destination group codes.
  localparam logic [1:0] TGT_CV     = 2'd0;
  localparam logic [1:0] TGT_KNOB   = 2'd1;
  localparam logic [1:0] TGT_BUTTON = 2'd2;

  // Parse phase of the current line.
  typedef enum logic [4:0] {
    PH_IDX_LEAD = 5'b00001,
    PH_IDX_WS   = 5'b00010,
    PH_IDX_NUM  = 5'b00100,
    PH_VAL_WS   = 5'b01000,
    PH_VAL_NUM  = 5'b10000
  } phase_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHR_ZERO) && (c <= CHR_NINE);
  endfunction

  function automatic logic is_soft_ws(input logic [7:0] c);
    return (c == CHR_TAB) || (c == CHR_VT) || (c == CHR_FF) || (c == CHR_CR);
  endfunction

endpackage

@@ hdl/ascii_control_line_parser.sv @@
// ----------------------------------------------------------------------------
// ASCII control line parser
// Parses "index space value newline" lines from a byte stream into
// target, channel and level results.
// ----------------------------------------------------------------------------
// The block takes one received character per transaction and emits at most one
// result, only when a newline (0x0A) arrives. A line names an index and a value
// separated by a space; both are read like atoi (whitespace, optional sign,
// decimal digits up to the first non-digit). Index 0-9 selects a cv input,
// 10-19 a knob and 30-39 a button; channel is the index minus the group base.
// The level is the value clamped to 0..1024 and stands for level/1024 of full
// scale. Lines without a separating space, with nothing after that space,
// with a negative or out-of-range index produce nothing. Each character is
// captured in an input register, and then the parse state and the result
// register are updated from it, so a new character is accepted in every
// cycle as long as the result register is free or being taken.
// ----------------------------------------------------------------------------
module ascii_control_line_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  target,
  output logic [3:0]  channel,
  output logic [10:0] level
);

  // Input register holding one character waiting to be parsed.
  logic       q_valid;
  logic [7:0] q_byte;

  // Parse state of the current line.
  aclp_pkg::phase_t phase, phase_next;
  logic [7:0]  index_accum, index_accum_next;
  logic        index_negative, index_negative_next;
  logic [10:0] value_accum, value_accum_next;
  logic        value_negative, value_negative_next;
  logic        value_present, value_present_next;
  logic        digits_ended, digits_ended_next;

  // Result of the character in the input register.
  logic        emit;
  logic [1:0]  tgt_next;
  logic [3:0]  ch_next;
  logic [10:0] lvl_next;

  logic        proc;
  logic        out_free;

  // The character is parsed once the result register can take its result:
  // it is empty or its transaction completes in this cycle.
  assign out_free = !out_valid || !out_stall;
  assign proc     = q_valid && out_free;
  assign in_stall = q_valid && !out_free;

  // Digit arithmetic, shared by every phase.
  logic [3:0]  digit;
  logic [11:0] idx_mul;
  logic [13:0] val_mul;
  logic [7:0]  idx_dig;
  logic [10:0] val_dig;
  logic [7:0]  idx_off;

  assign digit   = 4'(q_byte - aclp_pkg::CHR_ZERO);
  assign idx_mul = ({4'b0, index_accum} << 3) + ({4'b0, index_accum} << 1)
                 + {8'b0, digit};
  assign val_mul = ({3'b0, value_accum} << 3) + ({3'b0, value_accum} << 1)
                 + {10'b0, digit};
  assign idx_dig = (idx_mul > {4'b0, aclp_pkg::INDEX_SAT}) ? aclp_pkg::INDEX_SAT
                                                          : idx_mul[7:0];
  assign val_dig = (val_mul > {3'b0, aclp_pkg::VALUE_SAT}) ? aclp_pkg::VALUE_SAT
                                                          : val_mul[10:0];

  always_comb begin
    logic ok;
    logic in_group;
    logic is_dig;
    logic is_soft;
    phase_next          = phase;
    index_accum_next    = index_accum;
    index_negative_next = index_negative;
    value_accum_next    = value_accum;
    value_negative_next = value_negative;
    value_present_next  = value_present;
    digits_ended_next   = digits_ended;
    emit                = 1'b0;
    tgt_next            = aclp_pkg::TGT_CV;
    idx_off             = index_accum - aclp_pkg::CV_BASE;
    in_group            = 1'b1;
    is_dig              = aclp_pkg::is_digit(q_byte);
    is_soft             = aclp_pkg::is_soft_ws(q_byte);

    // Group decode of the finished index.
    if (index_accum < aclp_pkg::KNOB_BASE) begin
      tgt_next = aclp_pkg::TGT_CV;
      idx_off  = index_accum - aclp_pkg::CV_BASE;
    end else if (index_accum < aclp_pkg::KNOB_END) begin
      tgt_next = aclp_pkg::TGT_KNOB;
      idx_off  = index_accum - aclp_pkg::KNOB_BASE;
    end else if (index_accum >= aclp_pkg::BUTTON_BASE &&
                 index_accum < aclp_pkg::BUTTON_END) begin
      tgt_next = aclp_pkg::TGT_BUTTON;
      idx_off  = index_accum - aclp_pkg::BUTTON_BASE;
    end else begin
      in_group = 1'b0;
    end
    ch_next = idx_off[3:0];

    // A negative value gives level zero; a large one is clamped.
    if (value_negative) begin
      lvl_next = '0;
    end else if (value_accum > aclp_pkg::LEVEL_MAX) begin
      lvl_next = aclp_pkg::LEVEL_MAX;
    end else begin
      lvl_next = value_accum;
    end

    // A minus sign with zero magnitude still counts as index zero.
    ok = value_present && !(index_negative && index_accum != '0)
         && (index_accum != aclp_pkg::INDEX_SAT) && in_group;

    if (q_byte == aclp_pkg::CHR_NL) begin
      emit = ok && (phase == aclp_pkg::PH_VAL_WS || phase == aclp_pkg::PH_VAL_NUM);
      phase_next          = aclp_pkg::PH_IDX_LEAD;
      index_accum_next    = '0;
      index_negative_next = 1'b0;
      value_accum_next    = '0;
      value_negative_next = 1'b0;
      value_present_next  = 1'b0;
      digits_ended_next   = 1'b0;
    end else begin
      unique case (phase)
        aclp_pkg::PH_IDX_LEAD, aclp_pkg::PH_IDX_WS: begin
          if (q_byte == aclp_pkg::CHR_SPACE) begin
            // Leading spaces are skipped; after other whitespace a space
            // separates an empty index from the value.
            if (phase == aclp_pkg::PH_IDX_WS) phase_next = aclp_pkg::PH_VAL_WS;
          end else if (is_soft) begin
            phase_next = aclp_pkg::PH_IDX_WS;
          end else begin
            phase_next = aclp_pkg::PH_IDX_NUM;
            if (q_byte == aclp_pkg::CHR_MINUS) index_negative_next = 1'b1;
            else if (q_byte == aclp_pkg::CHR_PLUS) index_negative_next = index_negative;
            else if (is_dig) index_accum_next = idx_dig;
            else digits_ended_next = 1'b1;
          end
        end
        aclp_pkg::PH_IDX_NUM: begin
          if (q_byte == aclp_pkg::CHR_SPACE) begin
            phase_next        = aclp_pkg::PH_VAL_WS;
            digits_ended_next = 1'b0;
          end else if (!digits_ended && is_dig) begin
            index_accum_next = idx_dig;
          end else begin
            digits_ended_next = 1'b1;
          end
        end
        aclp_pkg::PH_VAL_WS: begin
          value_present_next = 1'b1;
          if (q_byte != aclp_pkg::CHR_SPACE && !is_soft) begin
            phase_next = aclp_pkg::PH_VAL_NUM;
            if (q_byte == aclp_pkg::CHR_MINUS) value_negative_next = 1'b1;
            else if (q_byte == aclp_pkg::CHR_PLUS) value_negative_next = value_negative;
            else if (is_dig) value_accum_next = val_dig;
            else digits_ended_next = 1'b1;
          end
        end
        aclp_pkg::PH_VAL_NUM: begin
          value_present_next = 1'b1;
          if (!digits_ended && is_dig) value_accum_next = val_dig;
          else digits_ended_next = 1'b1;
        end
        default: begin
          phase_next = aclp_pkg::PH_IDX_LEAD;
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
    if (!in_stall && in_valid) q_byte <= rx_byte;
  end

  // Parse state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= aclp_pkg::PH_IDX_LEAD;
      index_accum    <= '0;
      index_negative <= 1'b0;
      value_accum    <= '0;
      value_negative <= 1'b0;
      value_present  <= 1'b0;
      digits_ended   <= 1'b0;
    end else if (proc) begin
      phase          <= phase_next;
      index_accum    <= index_accum_next;
      index_negative <= index_negative_next;
      value_accum    <= value_accum_next;
      value_negative <= value_negative_next;
      value_present  <= value_present_next;
      digits_ended   <= digits_ended_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (proc && emit) begin
      target  <= tgt_next;
      channel <= ch_next;
      level   <= lvl_next;
    end
  end

  // A new result only ever follows a parsed newline.
  a_result_from_newline: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(proc && q_byte == aclp_pkg::CHR_NL))
    else $error("result appeared without a parsed newline");

  // Every parsed newline leaves the parser ready for a fresh line.
  a_newline_clears: assert property (@(posedge clk) disable iff (rst)
    (proc && q_byte == aclp_pkg::CHR_NL) |=>
      (phase == aclp_pkg::PH_IDX_LEAD && !value_present && index_accum == '0))
    else $error("parse state not cleared after newline");

  // A delivered result stays in range: level within full scale, a known target, channel at most 9.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level <= aclp_pkg::LEVEL_MAX && target <= aclp_pkg::TGT_BUTTON
                   && channel <= 4'd9))
    else $error("result field out of range");

endmodule
